// ----- design/assert_macros.svh -----
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/ffba_pkg.sv -----
// Types and constants of the first-fit block allocator.
package ffba_pkg;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_WRITE = 8'b0010_0000,
    S_MUL   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NOMEM = 2'd1;
  localparam status_t ST_ZERO  = 2'd2;

  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  localparam int ENT_W = 3;
  localparam logic [ENT_W-1:0] ENT_TAKEN = 3'b001;
  localparam logic [ENT_W-1:0] ENT_FIRST = 3'b010;
  localparam logic [ENT_W-1:0] ENT_NEXT  = 3'b100;
  localparam logic [7:0] ENT_TYPE_MASK   = 8'h0f;

endpackage

// ----- design/ffba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/first_fit_block_allocator.sv -----
// First-fit contiguous block allocator: top level.
//
//  channel   | handshake                 | word
//  ----------+---------------------------+--------------------------------------------
//  request   | in_valid / in_stall       | request_bytes
//  result    | out_valid / out_stall     | status, alloc_address, first_block, blocks_taken
//  config    | cfg_we                    | cfg_index, cfg_data
//
// After rst the table is swept to free, one entry a cycle; no word taken.
// A request holds the input through these steps (N = blocks taken): round up by shift
// (BLOCK_BYTES is a power of two), range check, a scan of the table read port up to the
// active size, N table writes, address multiply, result load and the return to idle.
// A zero-size request goes straight to the result load. The next request is taken
// while a result waits; a stalled result holds the sequencer in its last state until taken.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         request_bytes,
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::status_t   status,
  output logic [31:0]         alloc_address,
  output logic [9:0]          first_block,
  output logic [10:0]         blocks_taken,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import ffba_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = IDX_W + 1;
  localparam int BB_W  = $clog2(BLOCK_BYTES + 1);
  localparam int BB_SH = $clog2(BLOCK_BYTES);
  localparam int PW    = IDX_W + BB_W;
  localparam int LW    = (CNT_W > 11) ? CNT_W : 11;

  state_t           state;
  logic [31:0]      base_address;
  logic [10:0]      active_blocks;
  logic [CNT_W-1:0] limit;
  logic [LW-1:0]    active_wide;

  logic [32:0]      dq;

  logic [CNT_W-1:0] need_c;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] run;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_vld;
  logic [IDX_W-1:0] start;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] run_start;
  logic             ent_free;
  logic             hit;
  logic [PW-1:0]    prod;
  status_t          res_status;
  logic             res_load;

  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data;

  assign active_wide = (LW'(active_blocks) > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS)
                                                               : LW'(active_blocks);
  assign limit = CNT_W'(active_wide);

  assign ent_free  = ((ENT_W'(ENT_TYPE_MASK) & rd_data) & ENT_TAKEN) == '0;
  assign run_start = (run == '0) ? chk_idx : start;
  assign hit       = chk_vld && ent_free && ((run + 1'b1) == need_c);

  assign rd_en   = (state == S_SCAN) && (ptr < limit);
  assign wr_en   = (state == S_CLEAR) || (state == S_WRITE);
  assign wr_addr = ptr[IDX_W-1:0];
  assign wr_data = (state == S_CLEAR) ? '0 :
                   (ENT_TAKEN
                    | ((ptr[IDX_W-1:0] == start) ? ENT_FIRST : '0)
                    | ((ptr[IDX_W-1:0] == last)  ? '0 : ENT_NEXT));

  assign in_stall = (state != S_IDLE);
  assign res_load = (state == S_DONE) && (!out_valid || !out_stall);

  ffba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= '0;
      active_blocks <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:   base_address  <= cfg_data;
        REG_ACTIVE: active_blocks <= cfg_data[10:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      chk_vld   <= 1'b0;
    end else begin
      chk_vld <= rd_en;
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr[IDX_W-1:0] == IDX_W'(MAX_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (request_bytes == '0) begin
              res_status <= ST_ZERO;
              state      <= S_DONE;
            end else begin
              dq    <= 33'(request_bytes) + 33'(BLOCK_BYTES - 1);
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dq    <= dq >> BB_SH;
          state <= S_CHK;
        end
        S_CHK: begin
          if (dq > 33'(limit)) begin
            res_status <= ST_NOMEM;
            state      <= S_DONE;
          end else begin
            need_c <= CNT_W'(dq);
            ptr    <= '0;
            run    <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            ptr <= CNT_W'(run_start);
          end else if (rd_en) begin
            ptr <= ptr + 1'b1;
          end
          if (rd_en) begin
            chk_idx <= ptr[IDX_W-1:0];
          end
          if (chk_vld) begin
            if (!ent_free) begin
              run <= '0;
            end else if (!hit) begin
              run <= run + 1'b1;
              if (run == '0) begin
                start <= chk_idx;
              end
            end
            if (hit) begin
              start <= run_start;
              last  <= chk_idx;
              state <= S_WRITE;
            end else if ((CNT_W'(chk_idx) + 1'b1) == limit) begin
              res_status <= ST_NOMEM;
              state      <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          if (ptr[IDX_W-1:0] == last) begin
            res_status <= ST_OK;
            state      <= S_MUL;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_MUL: begin
          prod  <= PW'(start) * PW'(BLOCK_BYTES);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            status <= res_status;
            if (res_status == ST_OK) begin
              alloc_address <= base_address + 32'(prod);
              first_block   <= 10'(start);
              blocks_taken  <= 11'(need_c);
            end else begin
              alloc_address <= '0;
              first_block   <= '0;
              blocks_taken  <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `CHECK_NEXT(a_result_holds, out_valid && out_stall,
              out_valid && $stable(alloc_address) && $stable(status))
  `CHECK_NOW(a_fail_zero, out_valid && (status != ST_OK),
             (alloc_address == '0) && (first_block == '0) && (blocks_taken == '0))
  `CHECK_NOW(a_run_short, state == S_SCAN, run < need_c)
  `CHECK_NOW(a_write_span, state == S_WRITE,
             (ptr[IDX_W-1:0] >= start) && (ptr[IDX_W-1:0] <= last))

endmodule
